@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

@@ hdl/lmdu_pkg.sv @@
// Types, constants and the sqrt table of the LegS memory update block
`timescale 1ns / 1ps
`default_nettype none

package lmdu_pkg;

  localparam int DATA_W   = 32;
  localparam int SUM_W    = 48;
  localparam int WIDE_W   = 64;
  localparam int MUL_A_W  = 56;
  localparam int MUL_AL_W = 28;
  localparam int MUL_B_W  = 21;
  localparam int SQRT_W   = 20;
  localparam int DEN_W    = 23;
  localparam int DIV_W    = 72;
  localparam int DIV_BITS = 4;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int CNT_W    = 5;
  localparam int TAB_N    = 64;

  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_BWD  = 2'd1;
  localparam logic [1:0] MODE_TRAP = 2'd2;

  // register index is paddr[2]
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_STEP = 1'b1;

  localparam logic signed [WIDE_W-1:0] SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SUM_MIN = -64'sh0000_8000_0000_0000;
  localparam logic signed [WIDE_W-1:0] Y_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] Y_MIN   = -64'sh0000_0000_8000_0000;

  typedef enum logic [3:0] {
    OP_UD, OP_UDS, OP_FS, OP_XN, OP_TD, OP_XS, OP_BS, OP_BSD, OP_NDT, OP_YS
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t op;
    logic    mul_lo;
    logic    mul_hi;
    logic    div_load;
    logic    div_step;
    logic    out_load;
  } lmdu_cmd_t;

  typedef logic [TAB_N-1:0][SQRT_W-1:0] sqrt_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    rem   = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic sqrt_tab_t build_sqrt_tab();
    sqrt_tab_t   tab;
    logic [63:0] r;
    for (int n = 0; n < TAB_N; n++) begin
      r = isqrt64(64'(2 * n + 1) << 32);
      tab[n] = r[SQRT_W-1:0];
    end
    return tab;
  endfunction

  // floor(sqrt(2n+1) * 2^16)
  localparam sqrt_tab_t SQRT_TAB = build_sqrt_tab();

  function automatic logic signed [SUM_W-1:0] clip_sum(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = v;
    if (v > SUM_MAX) c = SUM_MAX;
    else if (v < SUM_MIN) c = SUM_MIN;
    return c[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/lmdu_ctrl.sv @@
// Sequencer for the multiply, divide and output steps of one request
`timescale 1ns / 1ps
`default_nettype none

module lmdu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         mode,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lmdu_pkg::lmdu_cmd_t     cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DLOAD = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  lmdu_pkg::mul_op_t              op_r, op_nxt;
  logic                           hi_r, hi_nxt;
  logic [lmdu_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           accept;
  logic                           out_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_load  = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    hi_nxt    = hi_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
          op_nxt    = lmdu_pkg::OP_UD;
          hi_nxt    = 1'b0;
        end
      end
      ST_MUL: begin
        hi_nxt = !hi_r;
        if (hi_r) begin
          case (op_r)
            lmdu_pkg::OP_UD:  op_nxt = lmdu_pkg::OP_UDS;
            lmdu_pkg::OP_UDS: op_nxt = (mode == lmdu_pkg::MODE_BWD) ? lmdu_pkg::OP_BS
                                                                     : lmdu_pkg::OP_FS;
            lmdu_pkg::OP_FS:  op_nxt = lmdu_pkg::OP_XN;
            lmdu_pkg::OP_XN:  op_nxt = lmdu_pkg::OP_TD;
            lmdu_pkg::OP_TD:  op_nxt = lmdu_pkg::OP_XS;
            lmdu_pkg::OP_XS: begin
              if (mode == lmdu_pkg::MODE_FWD) state_nxt = ST_HOLD;
              else op_nxt = lmdu_pkg::OP_BS;
            end
            lmdu_pkg::OP_BS:  op_nxt = lmdu_pkg::OP_BSD;
            lmdu_pkg::OP_BSD: op_nxt = lmdu_pkg::OP_NDT;
            lmdu_pkg::OP_NDT: state_nxt = ST_DLOAD;
            lmdu_pkg::OP_YS:  state_nxt = ST_HOLD;
            default:          state_nxt = ST_HOLD;
          endcase
        end
      end
      ST_DLOAD: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == lmdu_pkg::CNT_W'(lmdu_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
          op_nxt    = lmdu_pkg::OP_YS;
          hi_nxt    = 1'b0;
        end
      end
      ST_HOLD: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else out_valid_nxt = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= lmdu_pkg::OP_UD;
      hi_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      hi_r        <= hi_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.op       = op_r;
    cmd.mul_lo   = (state_r == ST_MUL) && !hi_r;
    cmd.mul_hi   = (state_r == ST_MUL) && hi_r;
    cmd.div_load = (state_r == ST_DLOAD);
    cmd.div_step = (state_r == ST_DIV);
    cmd.out_load = out_load;
  end

endmodule

`default_nettype wire

@@ hdl/lmdu_dp.sv @@
// Datapath: operand registers, shared split multiplier, radix-16 divider, sums
`timescale 1ns / 1ps
`default_nettype none

module lmdu_dp #(
  parameter int MAX_ORDER = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire lmdu_pkg::lmdu_cmd_t                cmd,
  input  wire logic [1:0]                         mode,
  input  wire logic [15:0]                        step_size,
  input  wire logic [5:0]                         in_coef_index,
  input  wire logic signed [lmdu_pkg::DATA_W-1:0] in_coef_in,
  input  wire logic signed [lmdu_pkg::DATA_W-1:0] in_sample_in,
  output logic signed [lmdu_pkg::DATA_W-1:0]      coef_out,
  output logic                                    saturated
);

  localparam int WW = lmdu_pkg::WIDE_W;

  logic signed [lmdu_pkg::DATA_W-1:0] x_r, u_r;
  logic [6:0]                         np1_r;
  logic [lmdu_pkg::SQRT_W-1:0]        s_r;
  logic signed [lmdu_pkg::SUM_W-1:0]  fsum_r, bsum_r;
  logic signed [WW-1:0]               ud_r, uds_r, t_r, f_r, bs_r, num_r;
  logic [lmdu_pkg::DEN_W-1:0]         ndt_r;
  logic [48:0]                        plo_r;
  logic [lmdu_pkg::DIV_W-1:0]         nq_r;
  logic [lmdu_pkg::DEN_W:0]           rem_r;
  logic [lmdu_pkg::DEN_W-1:0]         den_r;
  logic                               neg_r;
  logic signed [lmdu_pkg::DATA_W-1:0] coef_out_r;
  logic                               sat_r;

  logic [5:0]                         n_cl;
  logic                               row_start;
  logic signed [WW-1:0]               x64, a_sel, res, y_div, y_fin, ycl;
  logic [lmdu_pkg::MUL_B_W-1:0]       b_sel;
  logic [4:0]                         shamt;
  logic [48:0]                        plo;
  logic signed [49:0]                 phi;
  logic signed [79:0]                 full, prod_sh;
  logic                               ysat;
  logic [WW-1:0]                      mag;
  logic [lmdu_pkg::DEN_W-1:0]         den_v;
  logic [lmdu_pkg::DIV_W-1:0]         nq_load, nq_v;
  logic [lmdu_pkg::DEN_W:0]           rem_v;
  logic [WW-1:0]                      q;

  always_comb begin
    n_cl = in_coef_index;
    if (int'(in_coef_index) >= MAX_ORDER) n_cl = 6'(MAX_ORDER - 1);
  end
  assign row_start = (n_cl == 6'd0);
  assign x64       = {{(WW-lmdu_pkg::DATA_W){x_r[lmdu_pkg::DATA_W-1]}}, x_r};

  // operand select for the shared multiplier
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    shamt = 5'd16;
    case (cmd.op)
      lmdu_pkg::OP_UD: begin
        a_sel = {{(WW-lmdu_pkg::DATA_W){u_r[lmdu_pkg::DATA_W-1]}}, u_r};
        b_sel = 21'(step_size);
      end
      lmdu_pkg::OP_UDS: begin a_sel = ud_r;  b_sel = 21'(s_r); end
      lmdu_pkg::OP_FS: begin
        a_sel = {{(WW-lmdu_pkg::SUM_W){fsum_r[lmdu_pkg::SUM_W-1]}}, fsum_r};
        b_sel = 21'(s_r);
      end
      lmdu_pkg::OP_XN: begin a_sel = x64; b_sel = 21'(np1_r); shamt = 5'd0; end
      lmdu_pkg::OP_TD: begin
        a_sel = t_r; b_sel = 21'(step_size); shamt = mode[1] ? 5'd17 : 5'd16;
      end
      lmdu_pkg::OP_XS: begin a_sel = x64; b_sel = 21'(s_r); end
      lmdu_pkg::OP_BS: begin
        a_sel = {{(WW-lmdu_pkg::SUM_W){bsum_r[lmdu_pkg::SUM_W-1]}}, bsum_r};
        b_sel = 21'(s_r);
      end
      lmdu_pkg::OP_BSD: begin
        a_sel = bs_r; b_sel = 21'(step_size); shamt = mode[1] ? 5'd17 : 5'd16;
      end
      lmdu_pkg::OP_NDT: begin
        a_sel = WW'(np1_r); b_sel = 21'(step_size); shamt = 5'd0;
      end
      lmdu_pkg::OP_YS: begin a_sel = ycl; b_sel = 21'(s_r); end
      default: begin a_sel = '0; b_sel = '0; end
    endcase
  end

  // low partial product first, high partial product and floor shift next
  assign plo     = a_sel[lmdu_pkg::MUL_AL_W-1:0] * b_sel;
  assign phi     = $signed(a_sel[lmdu_pkg::MUL_A_W-1:lmdu_pkg::MUL_AL_W]) *
                   $signed({1'b0, b_sel});
  assign full    = $signed({{2{phi[49]}}, phi, 28'b0}) + $signed({31'b0, plo_r});
  assign prod_sh = full >>> shamt;
  assign res     = prod_sh[WW-1:0];

  // divide: round(|num| * 2^k / den) = floor((|num| * 2^k + den/2) / den)
  assign den_v   = (mode[1] ? 23'd131072 : 23'd65536) + ndt_r;
  assign mag     = num_r[WW-1] ? WW'(-num_r) : WW'(num_r);
  assign nq_load = (lmdu_pkg::DIV_W'(mag) << (mode[1] ? 17 : 16)) +
                   lmdu_pkg::DIV_W'(den_v >> 1);

  always_comb begin
    rem_v = rem_r;
    nq_v  = nq_r;
    for (int i = 0; i < lmdu_pkg::DIV_BITS; i++) begin
      rem_v = {rem_v[lmdu_pkg::DEN_W-1:0], nq_v[lmdu_pkg::DIV_W-1]};
      nq_v  = {nq_v[lmdu_pkg::DIV_W-2:0], 1'b0};
      if (rem_v >= {1'b0, den_r}) begin
        rem_v    = rem_v - {1'b0, den_r};
        nq_v[0]  = 1'b1;
      end
    end
  end

  assign q     = nq_r[WW-1:0];
  assign y_div = neg_r ? -$signed(q) : $signed(q);
  assign y_fin = (mode == lmdu_pkg::MODE_FWD) ? f_r : y_div;

  always_comb begin
    ycl  = y_fin;
    ysat = 1'b0;
    if (y_fin > lmdu_pkg::Y_MAX) begin
      ycl = lmdu_pkg::Y_MAX; ysat = 1'b1;
    end else if (y_fin < lmdu_pkg::Y_MIN) begin
      ycl = lmdu_pkg::Y_MIN; ysat = 1'b1;
    end
  end

  // running sums, cleared at row start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsum_r <= '0;
      bsum_r <= '0;
    end else if (cmd.load && row_start) begin
      fsum_r <= '0;
      bsum_r <= '0;
    end else if (cmd.mul_hi && cmd.op == lmdu_pkg::OP_XS) begin
      fsum_r <= lmdu_pkg::clip_sum(
                  {{(WW-lmdu_pkg::SUM_W){fsum_r[lmdu_pkg::SUM_W-1]}}, fsum_r} + res);
    end else if (cmd.mul_hi && cmd.op == lmdu_pkg::OP_YS) begin
      bsum_r <= lmdu_pkg::clip_sum(
                  {{(WW-lmdu_pkg::SUM_W){bsum_r[lmdu_pkg::SUM_W-1]}}, bsum_r} + res);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_coef_in;
      u_r   <= in_sample_in;
      np1_r <= 7'(n_cl) + 7'd1;
      s_r   <= lmdu_pkg::SQRT_TAB[n_cl];
    end
    if (cmd.mul_lo) plo_r <= plo;
    if (cmd.mul_hi) begin
      case (cmd.op)
        lmdu_pkg::OP_UD:  ud_r  <= res;
        lmdu_pkg::OP_UDS: uds_r <= res;
        lmdu_pkg::OP_FS:  t_r   <= res;
        lmdu_pkg::OP_XN:  t_r   <= t_r + res;
        lmdu_pkg::OP_TD:  f_r   <= x64 - res + uds_r;
        lmdu_pkg::OP_BS:  bs_r  <= res;
        lmdu_pkg::OP_BSD: num_r <= (mode == lmdu_pkg::MODE_BWD) ? x64 + uds_r - res
                                                                 : f_r - res;
        lmdu_pkg::OP_NDT: ndt_r <= res[lmdu_pkg::DEN_W-1:0];
        default: ;
      endcase
    end
    if (cmd.div_load) begin
      nq_r  <= nq_load;
      rem_r <= '0;
      den_r <= den_v;
      neg_r <= num_r[WW-1];
    end else if (cmd.div_step) begin
      nq_r  <= nq_v;
      rem_r <= rem_v;
    end
    if (cmd.out_load) begin
      coef_out_r <= ycl[lmdu_pkg::DATA_W-1:0];
      sat_r      <= ysat;
    end
  end

  assign coef_out  = coef_out_r;
  assign saturated = sat_r;

endmodule

`default_nettype wire

@@ hdl/legs_memory_discretized_update_core.sv @@
// LegS memory update: one coefficient per request, sequential.
// The work runs through a shared split multiplier, low partial product then
// high, and in all modes but forward Euler through a radix-16 divider. No new
// request is taken while one is in flight; the next can be taken in the cycle
// after the result is registered, once the output register is free.
// Synchronous active-low reset clears control and sums and sets mode and step.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module legs_memory_discretized_update_core #(
  parameter int MAX_ORDER = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [5:0]                         in_coef_index,
  input  wire logic signed [lmdu_pkg::DATA_W-1:0] in_coef_in,
  input  wire logic signed [lmdu_pkg::DATA_W-1:0] in_sample_in,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [lmdu_pkg::DATA_W-1:0]      out_coef_out,
  output logic                                    out_saturated,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  logic [1:0]          mode_r;
  logic [15:0]         step_r;
  logic                cfg_wr;
  lmdu_pkg::lmdu_cmd_t cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lmdu_pkg::MODE_FWD;
      step_r <= 16'd655;
    end else if (cfg_wr) begin
      case (paddr[2])
        lmdu_pkg::REG_MODE: mode_r <= pwdata[1:0];
        lmdu_pkg::REG_STEP: step_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == lmdu_pkg::REG_STEP) ? {16'b0, step_r} : {30'b0, mode_r};

  lmdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lmdu_dp #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .mode          (mode_r),
    .step_size     (step_r),
    .in_coef_index (in_coef_index),
    .in_coef_in    (in_coef_in),
    .in_sample_in  (in_sample_in),
    .coef_out      (out_coef_out),
    .saturated     (out_saturated)
  );

  // one request at a time
  `ASSERT_CLK(a_one_in_flight, in_valid && in_ready |=> !in_ready, "request taken while busy")
  `ASSERT_CLK(a_sat_at_rail, out_valid && out_saturated |-> (out_coef_out == 32'sh7FFF_FFFF || out_coef_out == -32'sh8000_0000), "saturated flag without rail value")
  `ASSERT_NEVER(a_load_exclusive, cmd.load && (cmd.mul_hi || cmd.div_step || cmd.out_load), "load overlaps work")

endmodule

`default_nettype wire

@@ tb/sv/lmdu_checker.sv @@
// Checker for the LegS memory update core: predicts each request's result and compares
`timescale 1ns / 1ps
`default_nettype none

module lmdu_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [5:0]         in_coef_index,
  input  wire logic signed [31:0] in_coef_in,
  input  wire logic signed [31:0] in_sample_in,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] out_coef_out,
  input  wire logic               out_saturated,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               pready,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output int                      errors,
  output int                      pending,
  output int                      n_checked,
  output int                      n_clipped
);

  typedef struct {
    logic signed [31:0] coef;
    logic               sat;
  } coef_result_t;

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -64'sh0000_8000_0000_0000;
  localparam longint Y_HI   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Y_LO   = -64'sh0000_0000_8000_0000;

  coef_result_t coef_q[$];
  logic [1:0]   cur_mode;
  logic [15:0]  cur_dt;
  longint       fwd_acc;
  longint       bwd_acc;
  longint       root_tab[64];

  // floor(a*b / 2^k), exact
  function automatic longint mul_floor(longint a, longint b, int k);
    logic signed [127:0] p;
    p = a;
    p = p * b;
    return longint'(p >>> k);
  endfunction

  // round(num * 2^k / den), ties away from zero
  function automatic longint div_near(longint num, longint den, int k);
    longint unsigned m, q, r, res;
    m   = (num < 0) ? longint'(-num) : num;
    q   = m / den;
    r   = m % den;
    res = (q << k) + ((r << k) + den / 2) / den;
    return (num < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint sat48(longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  function automatic coef_result_t legs_update(int n, longint x, longint u);
    coef_result_t res;
    longint s, dt, uds, t, y;
    dt = cur_dt;
    if (n == 0) begin
      fwd_acc = 0;
      bwd_acc = 0;
    end
    s   = root_tab[n];
    uds = mul_floor(mul_floor(u, dt, 16), s, 16);
    if (cur_mode == lmdu_pkg::MODE_FWD) begin
      t = mul_floor(fwd_acc, s, 16) + x * (n + 1);
      y = x - mul_floor(t, dt, 16) + uds;
      fwd_acc = sat48(fwd_acc + mul_floor(x, s, 16));
    end else if (cur_mode == lmdu_pkg::MODE_BWD) begin
      t = x + uds - mul_floor(mul_floor(bwd_acc, s, 16), dt, 16);
      y = div_near(t, 65536 + (n + 1) * dt, 16);
    end else begin
      // trapezoidal (mode 3 too): dt/2 products carry 17 fraction bits
      t = mul_floor(fwd_acc, s, 16) + x * (n + 1);
      t = x - mul_floor(t, dt, 17) + uds;
      fwd_acc = sat48(fwd_acc + mul_floor(x, s, 16));
      t = t - mul_floor(mul_floor(bwd_acc, s, 16), dt, 17);
      y = div_near(t, 131072 + (n + 1) * dt, 17);
    end
    res.sat = 1'b0;
    if (y > Y_HI) begin
      y = Y_HI;
      res.sat = 1'b1;
    end else if (y < Y_LO) begin
      y = Y_LO;
      res.sat = 1'b1;
    end
    if (cur_mode != lmdu_pkg::MODE_FWD) bwd_acc = sat48(bwd_acc + mul_floor(y, s, 16));
    res.coef = y[31:0];
    return res;
  endfunction

  initial begin
    longint tgt, lo, hi, mid;
    for (int n = 0; n < 64; n++) begin
      tgt = longint'(2 * n + 1) << 32;
      lo = 0;
      hi = 1 << 21;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= tgt) lo = mid;
        else hi = mid - 1;
      end
      root_tab[n] = lo;
    end
    errors = 0;
    n_checked = 0;
    n_clipped = 0;
  end

  assign pending = coef_q.size();

  always @(posedge clk) begin
    coef_result_t want;
    if (!rst_n) begin
      cur_mode <= lmdu_pkg::MODE_FWD;
      cur_dt   <= 16'd655;
      fwd_acc  = 0;
      bwd_acc  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == lmdu_pkg::REG_MODE) cur_mode <= pwdata[1:0];
        else cur_dt <= pwdata[15:0];
      end
      if (in_valid && in_ready)
        coef_q.push_back(legs_update(int'(in_coef_index), in_coef_in, in_sample_in));
      if (out_valid && out_ready) begin
        if (coef_q.size() == 0) begin
          $error("result with no request outstanding: coef_out %0d", out_coef_out);
          errors++;
        end else begin
          want = coef_q.pop_front();
          n_checked++;
          if (want.sat) n_clipped++;
          if (out_coef_out !== want.coef) begin
            $error("coef_out expected %0d actual %0d", want.coef, out_coef_out);
            errors++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated expected %0d actual %0d", want.sat, out_saturated);
            errors++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_legs_memory_discretized_update_core.sv @@
// Testbench top for the LegS memory update core: stimulus, register setup and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_legs_memory_discretized_update_core;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [5:0]         in_coef_index = '0;
  logic signed [31:0] in_coef_in = '0;
  logic signed [31:0] in_sample_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_coef_out;
  logic               out_saturated;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors, pending, n_checked, n_clipped;
  int                 n_sent = 0;
  bit                 steady = 1'b0;
  logic [1:0]         modes [8] = '{lmdu_pkg::MODE_FWD, lmdu_pkg::MODE_BWD,
                                    lmdu_pkg::MODE_TRAP, 2'd3,
                                    lmdu_pkg::MODE_FWD, lmdu_pkg::MODE_BWD,
                                    lmdu_pkg::MODE_TRAP, lmdu_pkg::MODE_TRAP};
  logic [15:0]        steps [8] = '{16'd65535, 16'd1, 16'd0, 16'd40000,
                                    16'd0, 16'd65535, 16'd65535, 16'd1};

  always #5 clk = ~clk;

  legs_memory_discretized_update_core dut (.*);

  lmdu_checker chk (.*);

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result-side stalls
  initial begin
    int g;
    forever begin
      @(posedge clk);
      out_ready <= 1'b1;
      g = gap_len();
      if (g > 0) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic reg_write(logic reg_id, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_id, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_coef(logic [5:0] n, logic [31:0] x, logic [31:0] u);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_coef_index <= n;
    in_coef_in    <= x;
    in_sample_in  <= u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic run_rows(int count);
    int len;
    logic [31:0] u;
    while (count > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 12);
        u = rand_val();
        for (int i = 0; i < len; i++) begin
          send_coef(6'(i), rand_val(), u);
          // occasional broken row: sample changes mid-row
          if ($urandom_range(0, 19) == 0) u = rand_val();
        end
        count -= len;
      end else begin
        send_coef(6'($urandom_range(0, 63)), rand_val(), rand_val());
        count--;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset setting, extremes and row restarts
    steady = 1'b1;
    send_coef(6'd0, 32'h0001_0000, 32'h0002_0000);
    send_coef(6'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coef(6'd2, 32'h8000_0000, 32'h8000_0000);
    send_coef(6'd63, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coef(6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_coef(6'd63, 32'h0, 32'hFFFF_FFFF);
    steady = 1'b0;
    drain();
    for (int p = 0; p < 4; p++) begin
      reg_write(lmdu_pkg::REG_MODE, {30'd0, modes[p]});
      reg_write(lmdu_pkg::REG_STEP, {16'd0, steps[p]});
      send_coef(6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_coef(6'd1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_coef(6'd63, 32'h7FFF_FFFF, 32'h8000_0000);
      send_coef(6'd0, 32'hFFFF_0000, 32'h0000_8000);
      drain();
    end

    // random rows under each setting
    for (int p = 0; p < 8; p++) begin
      reg_write(lmdu_pkg::REG_MODE, {30'd0, modes[p]});
      reg_write(lmdu_pkg::REG_STEP, {16'd0, steps[p]});
      steady = (p == 3);
      run_rows(60);
      drain();
    end
    for (int p = 0; p < 6; p++) begin
      reg_write(lmdu_pkg::REG_MODE, {30'd0, 2'($urandom_range(0, 3))});
      reg_write(lmdu_pkg::REG_STEP, {16'd0, 16'($urandom())});
      run_rows(50);
      drain();
    end

    $display("Sent %0d coefficients over all modes and step extremes; %0d results checked,",
             n_sent, n_checked);
    $display("%0d of them clipped.", n_clipped);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
